// File: src/assert_macros.svh
// Assertion macros for the checker file of the key/value table.
// Needs nothing else; the clocked form takes an explicit clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock with an active-low reset.
`define KVT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the default clk_i / rst_ni pair.
`define KVT_ASSERT(lbl, prop, msg) \
  `KVT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/kvt_pkg.sv
// Shared constants, codes and controller command type for the key/value table.
// Used by kvt_ctrl, kvt_datapath, key_value_table_core and kvt_checker.
package kvt_pkg;

  // Table geometry.
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;

  // Fixed port field widths.
  localparam int FIELD_W  = 64;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_PUT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GET = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch request, key match and free slot
    logic execute;  // update table and load result register
  } kvt_cmd_t;

endpackage

// File: src/kvt_ctrl.sv
// Controller for the key/value table: request sequencing and output valid.
// Depends on kvt_pkg for the command type.
module kvt_ctrl import kvt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output kvt_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // Result register can take a new transaction when empty or being drained.
  assign out_free      = !out_valid_q || !out_stall_i;
  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.execute = (state_q == S_EXEC) && out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Advance state and hold the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.execute) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: src/kvt_datapath.sv
// Datapath for the key/value table: entry registers, parallel key match,
// free slot pick, table update and result register. Depends on kvt_pkg.
module kvt_datapath import kvt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kvt_cmd_t              cmd_i,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [VALUE_BITS-1:0] value_out_o
);

  // Table storage.
  logic [ENTRIES-1:0]    entry_valid_q;
  logic [KEY_BITS-1:0]   entry_key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] entry_value_q [ENTRIES];

  // Captured request.
  logic [REQ_W-1:0]      req_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [ENTRIES-1:0]    hit_vec_q;
  logic [ENTRIES-1:0]    free_oh_q;

  // Result register.
  logic [STATUS_W-1:0]   status_q;
  logic [VALUE_BITS-1:0] rd_q;

  logic [ENTRIES-1:0]    hit_vec_d;
  logic [ENTRIES-1:0]    free_oh_d;
  logic                  any_hit;
  logic                  any_free;
  logic                  is_put;
  logic                  is_del;
  logic                  is_get;
  logic                  put_new;
  logic [VALUE_BITS-1:0] rd_sel;
  logic [STATUS_W-1:0]   status_d;
  logic [VALUE_BITS-1:0] rd_d;

  // Compare the incoming key against every valid entry.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec_d[i] = entry_valid_q[i] && (entry_key_q[i] == key_i);
    end
  end

  // Lowest free slot as a one-hot vector; zero when the table is full.
  assign free_oh_d = ~entry_valid_q & (entry_valid_q + 1'b1);

  assign any_hit  = |hit_vec_q;
  assign any_free = |free_oh_q;
  assign is_put   = (req_q == REQ_PUT);
  assign is_del   = (req_q == REQ_DEL);
  assign is_get   = (req_q == REQ_GET);
  assign put_new  = is_put && !any_hit && any_free;

  // Select the matching value; at most one entry matches.
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec_q[i]) rd_sel = rd_sel | entry_value_q[i];
    end
  end

  // Form the result of the captured request.
  always_comb begin
    status_d = ST_MISS;
    rd_d     = '0;
    if (is_put) begin
      status_d = (any_hit || any_free) ? ST_OK : ST_FULL;
    end else if (is_del) begin
      if (any_hit) status_d = ST_OK;
    end else if (is_get) begin
      if (any_hit) begin
        status_d = ST_OK;
        rd_d     = rd_sel;
      end
    end
  end

  // Valid marks: set on a fresh put, drop on a delete hit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
    end else if (cmd_i.execute) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (put_new && free_oh_q[i]) entry_valid_q[i] <= 1'b1;
        if (is_del && hit_vec_q[i])  entry_valid_q[i] <= 1'b0;
      end
    end
  end

  // Capture the request, write entries and load the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= req_type_i;
      key_q     <= key_i;
      value_q   <= value_i;
      hit_vec_q <= hit_vec_d;
      free_oh_q <= free_oh_d;
    end
    if (cmd_i.execute) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (is_put && hit_vec_q[i]) entry_value_q[i] <= value_q;
        if (put_new && free_oh_q[i]) begin
          entry_key_q[i]   <= key_q;
          entry_value_q[i] <= value_q;
        end
      end
      status_q <= status_d;
      rd_q     <= rd_d;
    end
  end

  assign status_o    = status_q;
  assign value_out_o = rd_q;

endmodule

// File: src/key_value_table_core.sv
// Key/value table core: 16-entry associative store with put, delete and get.
// Flow: the request is captured with its key match and free slot, then executed into the result register.
// Throughput: a new transaction is taken only after the captured one has executed; execution
// waits while a stalled result is held in the result register, and in_stall_o stays high.
// Reset: rst_ni asynchronous, clears all valid marks and control at once; no clearing pass.
// Depends on kvt_pkg, kvt_ctrl and kvt_datapath.
module key_value_table_core import kvt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [FIELD_W-1:0]  key_i,
  input  logic [FIELD_W-1:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [FIELD_W-1:0]  value_out_o
);

  kvt_cmd_t              cmd;
  logic [VALUE_BITS-1:0] rd_value;

  kvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  kvt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_type_i  (req_type_i),
    .key_i       (key_i[KEY_BITS-1:0]),
    .value_i     (value_i[VALUE_BITS-1:0]),
    .status_o    (status_o),
    .value_out_o (rd_value)
  );

  // Zero-extend the stored value to the port width.
  assign value_out_o = FIELD_W'(rd_value);

endmodule

// File: src/kvt_checker.sv
// Port-level checker for key_value_table_core, attached by bind.
// Depends on kvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvt_checker import kvt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [FIELD_W-1:0]  value_out_o
);

  // Hold a stalled result.
  `KVT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(value_out_o), "stalled result changed")

  // Block new transactions while one is in flight.
  `KVT_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "input accepted back to back")

  // Deliver the result when the output register is free in the execute state after acceptance.
  `KVT_ASSERT(a_result_latency, (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o, "result not delivered")

  // Report a value only with a found status, and no unused code.
  `KVT_ASSERT(a_status_value, out_valid_o && (status_o != ST_OK) |-> (value_out_o == '0) && (status_o == ST_MISS || status_o == ST_FULL), "bad status or value")

endmodule

bind key_value_table_core kvt_checker u_kvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .value_out_o (value_out_o)
);
